[hdl/assert_macros.svh]
// Assertion macros shared by the fire decay filter RTL.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define FDF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define FDF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/fdf_pkg.sv]
// Package for the fire decay filter: frame geometry, widths and payload types.
// Used by the filter unit and its testbench; depends on nothing.
`default_nettype none

package fdf_pkg;

   localparam int FRAME_WIDTH  = 128;
   localparam int FRAME_HEIGHT = 160;

   localparam int COL_W  = $clog2(FRAME_WIDTH);
   localparam int ROW_W  = $clog2(FRAME_HEIGHT);
   localparam int POS_W  = 10;
   localparam int HEAT_W = 8;
   localparam int SUM_W  = HEAT_W + 3;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);

   localparam logic [HEAT_W-1:0] DECAY_RESET = HEAT_W'(4);

   typedef struct packed {
      logic [HEAT_W-1:0] heat_in;
      logic              frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_column;
      logic [HEAT_W-1:0] heat_out;
      logic              frame_done;
      logic              frame_hot;
   } rsp_payload_type;

endpackage

`default_nettype wire

[hdl/fdf_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; holds the row stores of the fire decay filter.
`default_nettype none

module fdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/fire_decay_filter_unit.sv]
// Fire decay filter: takes one heat pixel per clock in raster order while req_ready is high
// and returns the decayed value of each pixel in rows 1 to 157 and columns 1 to 125, then one
// status transfer after the last pixel of a frame. A result is presented on rsp once the pixel
// that completes its neighborhood leaves stage one: the row-store RAM read registers together
// with that pixel, and the sum is taken into the output register when stage one advances.
// req_ready drops only while a result waits on rsp and the pixel held in stage one has a result
// of its own. The row stores need no clearing pass after reset.
`default_nettype none

`include "assert_macros.svh"

module fire_decay_filter_unit
   import fdf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_payload_type   req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  wire logic              csr_write_enable,
   input  wire logic [HEAT_W-1:0] csr_write_data
);

   logic [HEAT_W-1:0] decay_ff;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_cur;
   logic [COL_W-1:0]  col_cur;
   logic              accept;

   logic              s1_valid_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [HEAT_W-1:0] s1_heat_ff;
   logic              s1_start_ff;
   logic              upd_hit_ff, upd_hit_in;
   logic [HEAT_W-1:0] upd_fwd_ff;
   logic              orig_hit_ff, orig_hit_in;
   logic [HEAT_W-1:0] orig_fwd_ff;

   logic [HEAT_W-1:0] win_a_ff, win_b_ff;
   logic [HEAT_W-1:0] pend0_ff, pend1_ff;
   logic [HEAT_W-1:0] upd_m1_ff, upd_m2_ff;
   logic [HEAT_W-1:0] left_ff;
   logic              hot_seen_ff, hot_seen_in;

   logic              rsp_valid_ff;
   rsp_payload_type   rsp_payload_ff;

   logic [HEAT_W-1:0] upd_rd_data, orig_rd_data;
   logic [HEAT_W-1:0] upd_cur, above_orig, placed;
   logic [COL_W-1:0]  back_addr;
   logic              row_inner, compute, use_left, last_pixel, produce;
   logic              out_free, s1_adv, wr_en;
   logic [SUM_W-1:0]  sum;
   logic [HEAT_W-1:0] avg, new_heat;
   logic              hot, hot_now;

   // Position of the incoming pixel; a start mark forces row 0, column 0.
   assign row_cur = req_payload.frame_start ? '0 : row_ff;
   assign col_cur = req_payload.frame_start ? '0 : col_ff;

   always_comb begin
      row_in = row_cur;
      col_in = col_cur + COL_W'(1);
      if (col_cur == COL_LAST) begin
         col_in = '0;
         row_in = (row_cur == ROW_LAST) ? '0 : row_cur + ROW_W'(1);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && (!produce || out_free);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;
   assign wr_en     = s1_adv;

   assign back_addr = (s1_col_ff >= COL_W'(2)) ? s1_col_ff - COL_W'(2)
                                                : COL_W'(FRAME_WIDTH - 2) + s1_col_ff;

   // The pixel leaving stage one writes while the next pixel reads; forward on a match.
   assign upd_hit_in  = wr_en && (back_addr == col_cur);
   assign orig_hit_in = wr_en && (s1_col_ff == col_cur);

   fdf_ram #(.WIDTH(HEAT_W), .DEPTH(FRAME_WIDTH)) u_upd_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (back_addr),
      .wr_data (placed),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (upd_rd_data)
   );

   fdf_ram #(.WIDTH(HEAT_W), .DEPTH(FRAME_WIDTH)) u_orig_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (s1_heat_ff),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (orig_rd_data)
   );

   assign upd_cur    = upd_hit_ff ? upd_fwd_ff : upd_rd_data;
   assign above_orig = orig_hit_ff ? orig_fwd_ff : orig_rd_data;

   assign row_inner  = (s1_row_ff >= ROW_W'(2)) && (s1_row_ff <= ROW_W'(FRAME_HEIGHT - 2));
   assign compute    = row_inner && (s1_col_ff >= COL_W'(2))
                       && (s1_col_ff <= COL_W'(FRAME_WIDTH - 2));
   assign use_left   = row_inner && (s1_col_ff >= COL_W'(3));
   assign last_pixel = (s1_row_ff == ROW_LAST) && (s1_col_ff == COL_LAST);
   assign produce    = compute || last_pixel;
   assign placed     = use_left ? left_ff : pend1_ff;

   assign sum = SUM_W'(upd_m2_ff) + SUM_W'(upd_m1_ff) + SUM_W'(upd_cur)
              + SUM_W'(placed) + SUM_W'(above_orig)
              + SUM_W'(win_b_ff) + SUM_W'(win_a_ff) + SUM_W'(s1_heat_ff);
   assign avg      = sum[SUM_W-1:3];
   assign hot      = compute && (avg > decay_ff);
   assign new_heat = hot ? avg - decay_ff : '0;
   assign hot_now  = (s1_start_ff ? 1'b0 : hot_seen_ff) || hot;
   assign hot_seen_in = last_pixel ? 1'b0 : hot_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= DECAY_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hot_seen_ff  <= 1'b0;
         win_a_ff     <= '0;
         win_b_ff     <= '0;
         pend0_ff     <= '0;
         pend1_ff     <= '0;
         left_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            decay_ff <= csr_write_data;
         end
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv && produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            hot_seen_ff <= hot_seen_in;
            win_b_ff    <= win_a_ff;
            win_a_ff    <= s1_heat_ff;
            pend1_ff    <= pend0_ff;
            pend0_ff    <= above_orig;
            if (compute) begin
               left_ff <= new_heat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff   <= row_cur;
         s1_col_ff   <= col_cur;
         s1_heat_ff  <= req_payload.heat_in;
         s1_start_ff <= req_payload.frame_start;
         upd_hit_ff  <= upd_hit_in;
         upd_fwd_ff  <= placed;
         orig_hit_ff <= orig_hit_in;
         orig_fwd_ff <= s1_heat_ff;
      end
      if (s1_adv) begin
         upd_m2_ff <= upd_m1_ff;
         upd_m1_ff <= upd_cur;
      end
      if (s1_adv && produce) begin
         if (last_pixel) begin
            rsp_payload_ff.out_row    <= '0;
            rsp_payload_ff.out_column <= '0;
            rsp_payload_ff.heat_out   <= '0;
            rsp_payload_ff.frame_done <= 1'b1;
            rsp_payload_ff.frame_hot  <= hot_now;
         end else begin
            rsp_payload_ff.out_row    <= POS_W'(s1_row_ff) - POS_W'(1);
            rsp_payload_ff.out_column <= POS_W'(s1_col_ff) - POS_W'(1);
            rsp_payload_ff.heat_out   <= new_heat;
            rsp_payload_ff.frame_done <= 1'b0;
            rsp_payload_ff.frame_hot  <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `FDF_ASSERT_IMPLY(a_status_zero, rsp_valid && rsp_payload.frame_done,
      rsp_payload.heat_out == '0 && rsp_payload.out_row == '0
      && rsp_payload.out_column == '0, "status transfer carries pixel data")
   `FDF_ASSERT_IMPLY(a_pixel_column, rsp_valid && !rsp_payload.frame_done,
      rsp_payload.out_column >= POS_W'(1)
      && rsp_payload.out_column <= POS_W'(FRAME_WIDTH - 3), "pixel column outside interior")
   `FDF_ASSERT_IMPLY(a_stall_cause, !req_ready, s1_valid_ff && rsp_valid_ff,
      "input stalled without a pending result")
   `FDF_ASSERT_NEXT(a_stage_load, req_valid && req_ready, s1_valid_ff,
      "accepted pixel did not enter stage one")

endmodule

`default_nettype wire

[dv/tb_fire_decay_filter_unit.sv]
// Testbench for fire_decay_filter_unit: streams heat frames, predicts each decayed pixel and
// the end-of-frame status, and compares every rsp transfer against that prediction.
// Depends on fdf_pkg and the RTL of fire_decay_filter_unit only.
module tb_fire_decay_filter_unit;
   import fdf_pkg::*;

   typedef enum int {
      HEAT_ZERO,
      HEAT_FULL,
      HEAT_CHECKER,
      HEAT_UNIFORM,
      HEAT_COOL,
      HEAT_BLAZING
   } heat_pattern_type;

   localparam int IDLE_PERCENT = 32;
   localparam int HOLD_CYCLES  = 400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_payload_type   req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_payload_type   rsp_payload;
   logic              csr_write_enable = 1'b0;
   logic [HEAT_W-1:0] csr_write_data = '0;

   // Predicted state of the filter.
   logic [HEAT_W-1:0] updated_row [FRAME_WIDTH];
   logic [HEAT_W-1:0] original_row [FRAME_WIDTH];
   logic [HEAT_W-1:0] row_window [3];
   logic [HEAT_W-1:0] delayed_above [2];
   logic [HEAT_W-1:0] last_new_heat;
   logic [HEAT_W-1:0] decay_setting = DECAY_RESET;
   int                pixel_row;
   int                pixel_col;
   bit                frame_hot_seen;
   rsp_payload_type   expected_heat[$];

   int mismatch_count = 0;
   bit steady_flow = 1'b0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;

   fire_decay_filter_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Advances the predicted filter by one accepted pixel and queues what it produces.
   function void advance_pixel(input logic [HEAT_W-1:0] heat, input logic start);
      int              r;
      int              c;
      int              back;
      int unsigned     sum;
      int unsigned     avg;
      logic [HEAT_W-1:0] above;
      logic [HEAT_W-1:0] placed;
      rsp_payload_type res;
      if (start) begin
         pixel_row = 0;
         pixel_col = 0;
         frame_hot_seen = 1'b0;
      end
      r = pixel_row;
      c = pixel_col;
      above = original_row[c];
      row_window[0] = row_window[1];
      row_window[1] = row_window[2];
      row_window[2] = heat;
      back = (c >= 2) ? c - 2 : FRAME_WIDTH - 2 + c;
      if (c >= 3 && r >= 2 && r <= FRAME_HEIGHT - 2) begin
         placed = last_new_heat;
      end else begin
         placed = delayed_above[1];
      end
      if (c >= 2 && c <= FRAME_WIDTH - 2 && r >= 2 && r <= FRAME_HEIGHT - 2) begin
         sum = updated_row[c-2] + updated_row[c-1] + updated_row[c] + placed + above
             + row_window[0] + row_window[1] + row_window[2];
         avg = sum >> 3;
         if (avg > decay_setting) begin
            frame_hot_seen = 1'b1;
            avg = avg - decay_setting;
         end else begin
            avg = 0;
         end
         last_new_heat = avg[HEAT_W-1:0];
         res = '0;
         res.out_row = POS_W'(r - 1);
         res.out_column = POS_W'(c - 1);
         res.heat_out = avg[HEAT_W-1:0];
         expected_heat.push_back(res);
      end
      updated_row[back] = placed;
      original_row[c] = heat;
      delayed_above[1] = delayed_above[0];
      delayed_above[0] = above;
      if (r == FRAME_HEIGHT - 1 && c == FRAME_WIDTH - 1) begin
         res = '0;
         res.frame_done = 1'b1;
         res.frame_hot = frame_hot_seen;
         expected_heat.push_back(res);
      end
      c++;
      if (c >= FRAME_WIDTH) begin
         c = 0;
         r++;
         if (r >= FRAME_HEIGHT) begin
            r = 0;
            frame_hot_seen = 1'b0;
         end
      end
      pixel_row = r;
      pixel_col = c;
   endfunction

   function logic [HEAT_W-1:0] pick_heat(input heat_pattern_type pattern, input int index);
      case (pattern)
         HEAT_ZERO:    return '0;
         HEAT_FULL:    return '1;
         HEAT_CHECKER: return ((index / FRAME_WIDTH + index) % 2 != 0) ? '1 : '0;
         HEAT_COOL:    return HEAT_W'($urandom_range(0, 40));
         HEAT_BLAZING: return HEAT_W'($urandom_range(200, 255));
         default:      return HEAT_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%t: %s expected %0h, got %0h", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_heat.size() == 0) begin
            note_mismatch("unexpected transfer", '0, 32'(rsp_payload));
         end else begin
            want = expected_heat.pop_front();
            if (want.out_row !== rsp_payload.out_row)
               note_mismatch("out_row", want.out_row, rsp_payload.out_row);
            if (want.out_column !== rsp_payload.out_column)
               note_mismatch("out_column", want.out_column, rsp_payload.out_column);
            if (want.heat_out !== rsp_payload.heat_out)
               note_mismatch("heat_out", want.heat_out, rsp_payload.heat_out);
            if (want.frame_done !== rsp_payload.frame_done)
               note_mismatch("frame_done", want.frame_done, rsp_payload.frame_done);
            if (want.frame_hot !== rsp_payload.frame_hot)
               note_mismatch("frame_hot", want.frame_hot, rsp_payload.frame_hot);
         end
      end
   end

   // Receiver stalls at random (not in steady flow) or for a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (steady_flow) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   task automatic send_pixel(input logic [HEAT_W-1:0] heat, input logic start);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.heat_in <= heat;
      req_payload.frame_start <= start;
      do @(posedge clock); while (!req_ready);
      advance_pixel(heat, start);
   endtask

   task automatic send_stream(input heat_pattern_type pattern, input int count,
                              input logic mark);
      for (int i = 0; i < count; i++) begin
         send_pixel(pick_heat(pattern, i), (i == 0) ? mark : 1'b0);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_heat.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_decay(input logic [HEAT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      decay_setting = value;
   endtask

   // Runs with no idling on either side.
   task automatic test_reset_decay();
      steady_flow = 1'b1;
      send_stream(HEAT_FULL, 2 * FRAME_WIDTH + 8, 1'b1);
      send_stream(HEAT_CHECKER, 2 * FRAME_WIDTH + 8, 1'b1);
      drain_results();
      steady_flow = 1'b0;
   endtask

   task automatic test_decay_extremes();
      logic [HEAT_W-1:0] settings [4];
      settings = '{8'd0, 8'hFF, 8'd1, 8'hFE};
      send_stream(HEAT_FULL, 2 * FRAME_WIDTH + 2, 1'b1);
      foreach (settings[i]) begin
         drain_results();
         set_decay(settings[i]);
         send_stream(HEAT_FULL, FRAME_WIDTH / 4, 1'b0);
         send_stream(HEAT_UNIFORM, FRAME_WIDTH / 4, 1'b0);
      end
      drain_results();
   endtask

   task automatic test_backpressure();
      set_decay(HEAT_W'($urandom_range(0, 20)));
      send_stream(HEAT_UNIFORM, 2 * FRAME_WIDTH + 4, 1'b1);
      hold_requests++;
      send_stream(HEAT_BLAZING, FRAME_WIDTH, 1'b0);
      drain_results();
   endtask

   task automatic test_random_streams();
      int               sent;
      int               segment;
      int               length;
      int               choice;
      heat_pattern_type pattern;
      sent = 0;
      segment = 0;
      while (sent < 500) begin
         if (segment % 3 == 0) begin
            drain_results();
            choice = $urandom_range(0, 5);
            if (choice == 0) begin
               set_decay(8'd0);
            end else if (choice == 1) begin
               set_decay(8'hFF);
            end else if (choice < 4) begin
               set_decay(HEAT_W'($urandom_range(0, 32)));
            end else begin
               set_decay(HEAT_W'($urandom_range(0, 255)));
            end
         end
         pattern = heat_pattern_type'($urandom_range(HEAT_UNIFORM, HEAT_BLAZING));
         if ($urandom_range(0, 9) != 0) begin
            length = $urandom_range(2 * FRAME_WIDTH + 4, 3 * FRAME_WIDTH);
            send_stream(pattern, length, 1'b1);
         end else begin
            length = $urandom_range(1, 200);
            send_stream(pattern, length, 1'($urandom_range(0, 1)));
         end
         sent += length;
         segment++;
      end
      drain_results();
   endtask

   initial begin
      int waited;
      foreach (updated_row[i]) begin
         updated_row[i] = '0;
         original_row[i] = '0;
      end
      row_window = '{default: '0};
      delayed_above = '{default: '0};
      last_new_heat = '0;
      pixel_row = 0;
      pixel_col = 0;
      frame_hot_seen = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_decay();
      test_decay_extremes();
      test_backpressure();
      test_random_streams();

      req_valid <= 1'b0;
      waited = 0;
      while (expected_heat.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (expected_heat.size() != 0) begin
         $display("%0d expected results never arrived", expected_heat.size());
         mismatch_count += expected_heat.size();
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[fire_decay_filter_unit.f]
+incdir+hdl
hdl/fdf_pkg.sv
hdl/fdf_ram.sv
hdl/fire_decay_filter_unit.sv
dv/tb_fire_decay_filter_unit.sv
